FILE: rtl/spm_pkg.sv
// Package for the sparse polynomial term merge adder.
// Holds the command codes, the stored term layout and the controller/datapath
// interface structs. Depends on nothing.
`default_nettype none

package spm_pkg;

    localparam int unsigned CoeffWidth    = 16;
    localparam int unsigned ExpWidth      = 16;
    localparam int unsigned SumCoeffWidth = 17;
    localparam int unsigned CmdWidth      = 2;

    localparam logic [CmdWidth-1:0] CMD_LOAD_FIRST  = 2'd0;
    localparam logic [CmdWidth-1:0] CMD_LOAD_SECOND = 2'd1;
    localparam logic [CmdWidth-1:0] CMD_RUN         = 2'd2;

    typedef struct packed {
        logic signed [CoeffWidth-1:0] coeff;
        logic [ExpWidth-1:0]          exponent;
    } t_term;

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } t_state;

    typedef struct packed {
        logic load_first;
        logic load_second;
        logic step;
        logic clear;
    } t_dp_cmd;

    typedef struct packed {
        logic lists_empty;
        logic slot_free;
        logic final_term;
    } t_dp_status;

endpackage

`default_nettype wire

FILE: rtl/spm_ctrl.sv
// Controller of the sparse polynomial term merge adder.
// Decodes accepted requests and sequences the merge; uses spm_pkg.
`default_nettype none

module spm_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [spm_pkg::CmdWidth-1:0]  i_command,
    input  spm_pkg::t_dp_status                i_status,
    output spm_pkg::t_dp_cmd                   o_cmd,
    output logic                               o_busy
);

    spm_pkg::t_state r_state;
    spm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spm_pkg::ST_IDLE: begin
                if (i_accept && (i_command == spm_pkg::CMD_RUN) && !i_status.lists_empty) begin
                    n_state = spm_pkg::ST_MERGE;
                end
            end
            spm_pkg::ST_MERGE: begin
                if (i_status.slot_free && i_status.final_term) begin
                    n_state = spm_pkg::ST_IDLE;
                end
            end
            default: n_state = spm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b0;
        unique case (r_state)
            spm_pkg::ST_IDLE: begin
                if (i_accept) begin
                    unique case (i_command)
                        spm_pkg::CMD_LOAD_FIRST:  o_cmd.load_first  = 1'b1;
                        spm_pkg::CMD_LOAD_SECOND: o_cmd.load_second = 1'b1;
                        spm_pkg::CMD_RUN:         o_cmd.clear       = i_status.lists_empty;
                        default:                  o_cmd             = '0;
                    endcase
                end
            end
            spm_pkg::ST_MERGE: begin
                o_busy     = 1'b1;
                o_cmd.step = i_status.slot_free;
                o_cmd.clear = i_status.slot_free && i_status.final_term;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/spm_datapath.sv
// Datapath of the sparse polynomial term merge adder: term stores, counts,
// merge indices, coefficient adder and result register. Uses spm_pkg.
`default_nettype none

module spm_datapath #(
    parameter int unsigned MAX_TERMS = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  spm_pkg::t_dp_cmd                           i_cmd,
    input  wire logic signed [spm_pkg::CoeffWidth-1:0] i_term_coeff,
    input  wire logic [spm_pkg::ExpWidth-1:0]          i_term_exponent,
    input  wire logic                                  i_out_stall,
    output spm_pkg::t_dp_status                        o_status,
    output logic                                       o_out_valid,
    output logic signed [spm_pkg::SumCoeffWidth-1:0]   o_sum_coeff,
    output logic [spm_pkg::ExpWidth-1:0]               o_sum_exponent,
    output logic                                       o_last_term
);

    localparam int unsigned CW = $clog2(MAX_TERMS + 1);
    localparam int unsigned AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    spm_pkg::t_term r_first_terms  [MAX_TERMS];
    spm_pkg::t_term r_second_terms [MAX_TERMS];

    logic [CW-1:0] r_first_count;
    logic [CW-1:0] r_second_count;
    logic [CW-1:0] r_first_idx;
    logic [CW-1:0] r_second_idx;
    logic [CW-1:0] n_first_idx;
    logic [CW-1:0] n_second_idx;

    logic                                     r_out_valid;
    logic signed [spm_pkg::SumCoeffWidth-1:0] r_sum_coeff;
    logic [spm_pkg::ExpWidth-1:0]             r_sum_exponent;
    logic                                     r_last_term;

    spm_pkg::t_term                           r_head_a;
    spm_pkg::t_term                           r_head_b;
    spm_pkg::t_term                           new_term;
    logic [AW-1:0]                            rd_first_addr;
    logic [AW-1:0]                            rd_second_addr;
    logic                                     a_ok;
    logic                                     b_ok;
    logic                                     take_a;
    logic                                     take_b;
    logic                                     take_both;
    logic signed [spm_pkg::SumCoeffWidth-1:0] coeff_a;
    logic signed [spm_pkg::SumCoeffWidth-1:0] coeff_b;
    logic signed [spm_pkg::SumCoeffWidth-1:0] n_sum_coeff;
    logic                                     n_last;

    assign new_term.coeff    = i_term_coeff;
    assign new_term.exponent = i_term_exponent;

    assign coeff_a = {r_head_a.coeff[spm_pkg::CoeffWidth-1], r_head_a.coeff};
    assign coeff_b = {r_head_b.coeff[spm_pkg::CoeffWidth-1], r_head_b.coeff};

    always_comb begin
        a_ok      = r_first_idx < r_first_count;
        b_ok      = r_second_idx < r_second_count;
        take_both = a_ok && b_ok && (r_head_a.exponent == r_head_b.exponent);
        take_a    = a_ok && (!b_ok || (r_head_a.exponent > r_head_b.exponent));
        take_b    = b_ok && (!a_ok || (r_head_b.exponent > r_head_a.exponent));

        n_first_idx  = r_first_idx + CW'(take_a || take_both);
        n_second_idx = r_second_idx + CW'(take_b || take_both);
        n_last       = (n_first_idx >= r_first_count) && (n_second_idx >= r_second_count);

        if (take_both) begin
            n_sum_coeff = coeff_a + coeff_b;
        end else if (take_a) begin
            n_sum_coeff = coeff_a;
        end else begin
            n_sum_coeff = coeff_b;
        end
    end

    always_comb begin
        if (i_cmd.clear) begin
            rd_first_addr  = '0;
            rd_second_addr = '0;
        end else if (i_cmd.step) begin
            rd_first_addr  = n_first_idx[AW-1:0];
            rd_second_addr = n_second_idx[AW-1:0];
        end else begin
            rd_first_addr  = r_first_idx[AW-1:0];
            rd_second_addr = r_second_idx[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_first && (r_first_count < CW'(MAX_TERMS))) begin
            r_first_terms[r_first_count[AW-1:0]] <= new_term;
        end
        if (i_cmd.load_second && (r_second_count < CW'(MAX_TERMS))) begin
            r_second_terms[r_second_count[AW-1:0]] <= new_term;
        end
        r_head_a <= r_first_terms[rd_first_addr];
        r_head_b <= r_second_terms[rd_second_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_count  <= '0;
            r_second_count <= '0;
            r_first_idx    <= '0;
            r_second_idx   <= '0;
        end else if (i_cmd.clear) begin
            r_first_count  <= '0;
            r_second_count <= '0;
            r_first_idx    <= '0;
            r_second_idx   <= '0;
        end else begin
            if (i_cmd.load_first && (r_first_count < CW'(MAX_TERMS))) begin
                r_first_count <= r_first_count + CW'(1);
            end
            if (i_cmd.load_second && (r_second_count < CW'(MAX_TERMS))) begin
                r_second_count <= r_second_count + CW'(1);
            end
            if (i_cmd.step) begin
                r_first_idx  <= n_first_idx;
                r_second_idx <= n_second_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_sum_coeff    <= n_sum_coeff;
            r_sum_exponent <= take_b ? r_head_b.exponent : r_head_a.exponent;
            r_last_term    <= n_last;
        end
    end

    assign o_status.lists_empty = (r_first_count == '0) && (r_second_count == '0);
    assign o_status.slot_free   = !r_out_valid || !i_out_stall;
    assign o_status.final_term  = n_last;

    assign o_out_valid    = r_out_valid;
    assign o_sum_coeff    = r_sum_coeff;
    assign o_sum_exponent = r_sum_exponent;
    assign o_last_term    = r_last_term;

endmodule

`default_nettype wire

FILE: rtl/sparse_poly_term_merge_add_unit.sv
// Top level of the sparse polynomial term merge adder.
// Instantiates spm_ctrl and spm_datapath; uses spm_pkg.
//
// Load requests append one term to the first or second list; a list holds up
// to MAX_TERMS terms and further loads to it are dropped. A run request merges
// both lists, emitting one result term per cycle from the registered result
// stage while the output side does not stall, and gives at most twice
// MAX_TERMS result terms. The input is stalled for the whole merge, because
// both lists are walked by a single pair of read indices. A run with both
// lists empty completes in its accepting cycle and gives no result. After
// every run both lists are emptied. The last result term of a run carries
// o_last_term.
`default_nettype none

module sparse_poly_term_merge_add_unit #(
    parameter int unsigned MAX_TERMS = 32
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_in_valid,
    output logic                                          o_in_stall,
    input  wire logic [spm_pkg::CmdWidth-1:0]             i_command,
    input  wire logic signed [spm_pkg::CoeffWidth-1:0]    i_term_coeff,
    input  wire logic [spm_pkg::ExpWidth-1:0]             i_term_exponent,
    output logic                                          o_out_valid,
    input  wire logic                                     i_out_stall,
    output logic signed [spm_pkg::SumCoeffWidth-1:0]      o_sum_coeff,
    output logic [spm_pkg::ExpWidth-1:0]                  o_sum_exponent,
    output logic                                          o_last_term
);

    spm_pkg::t_dp_cmd    dp_cmd;
    spm_pkg::t_dp_status dp_status;
    logic                busy;
    logic                in_accept;

    assign in_accept  = i_in_valid && !busy;
    assign o_in_stall = busy;

    spm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_command (i_command),
        .i_status  (dp_status),
        .o_cmd     (dp_cmd),
        .o_busy    (busy)
    );

    spm_datapath #(
        .MAX_TERMS (MAX_TERMS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .i_term_coeff    (i_term_coeff),
        .i_term_exponent (i_term_exponent),
        .i_out_stall     (i_out_stall),
        .o_status        (dp_status),
        .o_out_valid     (o_out_valid),
        .o_sum_coeff     (o_sum_coeff),
        .o_sum_exponent  (o_sum_exponent),
        .o_last_term     (o_last_term)
    );

endmodule

`default_nettype wire

FILE: rtl/spm_checker.sv
// Port-level checker for the sparse polynomial term merge adder, with the
// bind that attaches it to sparse_poly_term_merge_add_unit. Uses spm_pkg.
`default_nettype none

module spm_checker (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  i_in_valid,
    input wire logic                                  o_in_stall,
    input wire logic [spm_pkg::CmdWidth-1:0]          i_command,
    input wire logic                                  o_out_valid,
    input wire logic                                  i_out_stall,
    input wire logic signed [spm_pkg::SumCoeffWidth-1:0] o_sum_coeff,
    input wire logic [spm_pkg::ExpWidth-1:0]          o_sum_exponent,
    input wire logic                                  o_last_term
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_sum_coeff) && $stable(o_sum_exponent)
            && $stable(o_last_term))
        else $error("Stalled result changed or was dropped.");

    a_merge_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |->
            $past(i_in_valid) && ($past(i_command) == spm_pkg::CMD_RUN))
        else $error("Merge began without an accepted run request.");

    a_mid_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_term |-> o_in_stall)
        else $error("Requests accepted while a run still had terms to give.");

    a_merge_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_stall) |-> o_out_valid && o_last_term)
        else $error("Merge ended without presenting its final term.");

endmodule

bind sparse_poly_term_merge_add_unit spm_checker u_spm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_command      (i_command),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_sum_coeff    (o_sum_coeff),
    .o_sum_exponent (o_sum_exponent),
    .o_last_term    (o_last_term)
);

`default_nettype wire
